[rtl/vwg_pkg.sv]
// Shared types and constants for the voltammetry waveform generator.
// Holds the segment and mode codes, register indexes and fixed pulse timing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vwg_pkg;

    localparam int unsigned LEVEL_W = 13;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned REG_W   = 12;
    localparam int unsigned SUM_W   = 14;

    localparam logic [COUNT_W-1:0] PULSE_LEAD = 13'd1000;
    localparam logic [COUNT_W-1:0] PULSE_END  = 13'd2000;
    localparam logic [COUNT_W-1:0] PULSE_LAST = 13'd3999;

    typedef enum logic [2:0] {
        SEG_IDLE     = 3'd0,
        SEG_TRI_UP   = 3'd1,
        SEG_TRI_DOWN = 3'd2,
        SEG_CV_A     = 3'd3,
        SEG_CV_B     = 3'd4,
        SEG_CV_C     = 3'd5,
        SEG_SWV      = 3'd6,
        SEG_PULSE    = 3'd7
    } t_segment;

    typedef enum logic [1:0] {
        MODE_TRIANGLE = 2'd0,
        MODE_CV       = 2'd1,
        MODE_SWV      = 2'd2,
        MODE_PULSE    = 2'd3
    } t_wave_mode;

    typedef enum logic [2:0] {
        CFG_WAVE_MODE    = 3'd0,
        CFG_START_LEVEL  = 3'd1,
        CFG_END_LEVEL    = 3'd2,
        CFG_GROUND_LEVEL = 3'd3,
        CFG_STEP_SIZE    = 3'd4,
        CFG_PULSE_HEIGHT = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [11:0]        dac_value;
        logic [COUNT_W-1:0] sample_index;
        logic               last_sample;
        logic               active;
    } t_result;

endpackage

`default_nettype wire

[rtl/voltammetry_waveform_generator.sv]
// Top level of the voltammetry waveform generator: sample sequencer and output queue.
// Depends on vwg_pkg.
//
// Channel   Direction  Signals                     Content
// s_axis    in         tvalid tready tdata[7:0]    restart
// m_axis    out        tvalid tready tdata[31:0]   dac_value, sample_index; tlast, tuser
// cfg       in         i_cfg_we i_cfg_addr i_cfg_data   register writes
//
// Each transfer in gives one result transfer out; a new item is taken every cycle.
// The sample is computed combinationally from the sequencer registers and lands in a
// two-entry output queue, so one result may wait while the next item is taken.
// Input stalls only when both queue entries are full.
// Reset is synchronous: the queue empties, registers take their defaults and the
// sequencer holds at level zero, inactive.
`timescale 1ns / 1ps
`default_nettype none

module voltammetry_waveform_generator
    import vwg_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned DAC_BITS    = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Bit 0: restart.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    // Bits 11:0 dac_value, 24:12 sample_index, 31:25 zero.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    // Bit 0: active.
    output logic             m_axis_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [11:0] i_cfg_data
);

    localparam int unsigned DAC_TOP = (1 << DAC_BITS) - 1;
    localparam logic [COUNT_W-1:0] CAP_LAST = COUNT_W'(MAX_SAMPLES - 1);

    function automatic logic [SUM_W-1:0] f_sat(input logic [SUM_W-1:0] v);
        if (32'(v) > DAC_TOP) begin
            return SUM_W'(DAC_TOP);
        end
        return v;
    endfunction

    t_wave_mode         r_wave_mode;
    logic [REG_W-1:0]   r_start_level;
    logic [REG_W-1:0]   r_end_level;
    logic [REG_W-1:0]   r_ground_level;
    logic [REG_W-1:0]   r_step_size;
    logic [REG_W-1:0]   r_pulse_height;

    t_segment           r_segment, n_segment;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_half, n_half;
    logic               r_finished, n_finished;

    t_result            r_q0, r_q1;
    logic [1:0]         r_fill;
    t_result            w_result;
    logic               w_in_take;
    logic               w_out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode    <= MODE_TRIANGLE;
            r_start_level  <= '0;
            r_end_level    <= '0;
            r_ground_level <= 12'd2048;
            r_step_size    <= 12'd1;
            r_pulse_height <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WAVE_MODE:    r_wave_mode    <= t_wave_mode'(i_cfg_data[1:0]);
                CFG_START_LEVEL:  r_start_level  <= i_cfg_data;
                CFG_END_LEVEL:    r_end_level    <= i_cfg_data;
                CFG_GROUND_LEVEL: r_ground_level <= i_cfg_data;
                CFG_STEP_SIZE:    r_step_size    <= i_cfg_data;
                CFG_PULSE_HEIGHT: r_pulse_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [SUM_W-1:0]   v_value;
        logic               v_last;
        logic               v_act;
        logic [REG_W-1:0]   v_inc;
        logic [SUM_W-1:0]   v_up;
        logic               v_ok;
        logic [LEVEL_W-1:0] v_next;
        logic [LEVEL_W-1:0] v_target;
        logic               v_done;
        logic [SUM_W-1:0]   v_low;

        n_segment  = r_segment;
        n_level    = r_level;
        n_count    = r_count;
        n_half     = r_half;
        n_finished = r_finished;
        v_value    = '0;
        v_last     = 1'b0;
        v_act      = 1'b1;
        v_done     = 1'b0;
        v_target   = '0;

        v_inc = (r_step_size == '0) ? REG_W'(1) : r_step_size;
        v_up  = SUM_W'(r_level) + SUM_W'(v_inc);
        if (r_start_level < r_end_level) begin
            v_ok   = (v_up <= SUM_W'(r_end_level));
            v_next = v_up[LEVEL_W-1:0];
        end else begin
            v_ok   = (r_level >= LEVEL_W'(v_inc))
                     && ((r_level - LEVEL_W'(v_inc)) >= LEVEL_W'(r_end_level));
            v_next = r_level - LEVEL_W'(v_inc);
        end
        v_low = (r_level >= LEVEL_W'(r_pulse_height))
                ? SUM_W'(r_level - LEVEL_W'(r_pulse_height)) : '0;

        if (s_axis_tdata[0]) begin
            n_count    = '0;
            n_half     = 1'b0;
            n_finished = 1'b0;
            unique case (r_wave_mode)
                MODE_TRIANGLE: begin
                    n_segment = SEG_TRI_UP;
                    n_level   = LEVEL_W'(r_start_level);
                    v_value   = f_sat(SUM_W'(r_start_level));
                end
                MODE_CV: begin
                    n_segment = SEG_CV_A;
                    n_level   = LEVEL_W'(r_ground_level);
                    v_value   = f_sat(SUM_W'(r_ground_level));
                end
                MODE_SWV: begin
                    n_segment = SEG_SWV;
                    n_level   = LEVEL_W'(r_start_level);
                    v_value   = f_sat(SUM_W'(r_start_level) + SUM_W'(r_pulse_height));
                end
                MODE_PULSE: begin
                    n_segment = SEG_PULSE;
                    n_level   = LEVEL_W'(r_start_level);
                    v_value   = f_sat(SUM_W'(r_start_level));
                end
                default: ;
            endcase
        end else if (r_finished || (r_segment == SEG_IDLE)) begin
            v_value = f_sat(SUM_W'(r_level));
            v_act   = 1'b0;
        end else begin
            n_count = r_count + 1'b1;
            if (r_segment == SEG_SWV) begin
                if (!r_half) begin
                    n_half  = 1'b1;
                    v_value = f_sat(v_low);
                    v_last  = !v_ok;
                end else begin
                    if (v_ok) begin
                        n_level = v_next;
                    end
                    n_half  = 1'b0;
                    v_value = f_sat(SUM_W'(n_level) + SUM_W'(r_pulse_height));
                end
            end else if (r_segment == SEG_PULSE) begin
                n_level = ((n_count < PULSE_LEAD) || (n_count >= PULSE_END))
                          ? LEVEL_W'(r_start_level) : LEVEL_W'(r_end_level);
                v_value = f_sat(SUM_W'(n_level));
                v_last  = (n_count >= PULSE_LAST);
            end else begin
                // A ramp may pass through up to three finished segments in one tick.
                v_value = f_sat(SUM_W'(r_level));
                for (int i = 0; i < 4; i++) begin
                    if (!v_done) begin
                        unique case (n_segment)
                            SEG_TRI_UP:   v_target = LEVEL_W'(r_end_level);
                            SEG_TRI_DOWN: v_target = LEVEL_W'(r_start_level);
                            SEG_CV_A:     v_target = LEVEL_W'(r_start_level);
                            SEG_CV_B:     v_target = LEVEL_W'(r_end_level);
                            SEG_CV_C:     v_target = LEVEL_W'(r_ground_level);
                            default:      v_target = n_level;
                        endcase
                        if (n_level != v_target) begin
                            n_level = (n_level < v_target) ? n_level + 1'b1 : n_level - 1'b1;
                            v_value = f_sat(SUM_W'(n_level));
                            v_done  = 1'b1;
                        end else begin
                            unique case (n_segment)
                                SEG_TRI_UP: n_segment = SEG_TRI_DOWN;
                                SEG_CV_A:   n_segment = SEG_CV_B;
                                SEG_CV_B:   n_segment = SEG_CV_C;
                                default: begin
                                    n_level = ((n_segment == SEG_TRI_DOWN)
                                               || (n_segment == SEG_TRI_UP))
                                              ? LEVEL_W'(r_start_level)
                                              : LEVEL_W'(r_ground_level);
                                    v_value = f_sat(SUM_W'(n_level));
                                    v_last  = 1'b1;
                                    v_done  = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
        end

        if (v_act && (n_count >= CAP_LAST)) begin
            v_last = 1'b1;
        end
        if (v_last) begin
            n_finished = 1'b1;
            n_level    = v_value[LEVEL_W-1:0];
            n_segment  = SEG_IDLE;
            n_half     = 1'b0;
        end

        w_result.dac_value    = v_value[11:0];
        w_result.sample_index = n_count;
        w_result.last_sample  = v_last;
        w_result.active       = v_act;
    end

    assign s_axis_tready = (r_fill != 2'd2);
    assign m_axis_tvalid = (r_fill != 2'd0);
    assign w_in_take     = s_axis_tvalid && s_axis_tready;
    assign w_out_take    = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment  <= SEG_IDLE;
            r_level    <= '0;
            r_count    <= '0;
            r_half     <= 1'b0;
            r_finished <= 1'b1;
        end else if (w_in_take) begin
            r_segment  <= n_segment;
            r_level    <= n_level;
            r_count    <= n_count;
            r_half     <= n_half;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            priority if (w_in_take && !w_out_take) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_out_take && !w_in_take) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take) begin
            if (w_in_take && (r_fill == 2'd1)) begin
                r_q0 <= w_result;
            end else begin
                r_q0 <= r_q1;
            end
            if (w_in_take && (r_fill == 2'd2)) begin
                r_q1 <= w_result;
            end
        end else if (w_in_take) begin
            if (r_fill == 2'd0) begin
                r_q0 <= w_result;
            end else begin
                r_q1 <= w_result;
            end
        end
    end

    assign m_axis_tdata = {7'd0, r_q0.sample_index, r_q0.dac_value};
    assign m_axis_tlast = r_q0.last_sample;
    assign m_axis_tuser = r_q0.active;

endmodule

`default_nettype wire

[tb/vwg_sample_checker.sv]
// Checker for the voltammetry waveform generator: predicts each DAC sample from the
// restart transfers and register writes it observes, then compares the results.
// Depends on vwg_pkg.
`timescale 1ns / 1ps

module vwg_sample_checker
    import vwg_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned DAC_BITS    = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // Bit 0: restart.
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,    // Bits 11:0 dac_value, 24:12 sample_index.
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,    // Bit 0: active.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors
);

    localparam int unsigned DAC_TOP = (1 << DAC_BITS) - 1;

    t_wave_mode   mode_r;
    logic [11:0]  start_r, end_r, gnd_r, step_r, height_r;

    t_segment     seg_q;
    logic [12:0]  lvl_q;
    logic [12:0]  cnt_q;
    logic         half_q;
    logic         done_q;

    t_result      expected_samples[$];
    t_result      want, got;
    int           err_cnt;

    function automatic bit swv_advance(output int unsigned nxt);
        int unsigned inc;
        inc = (step_r == 0) ? 1 : step_r;
        nxt = 32'(lvl_q);
        if (start_r < end_r) begin
            nxt = lvl_q + inc;
            return nxt <= end_r;
        end
        if (lvl_q < inc || lvl_q - inc < end_r) return 1'b0;
        nxt = lvl_q - inc;
        return 1'b1;
    endfunction

    function automatic t_result next_sample(input logic restart);
        t_result      r;
        int unsigned  val, nxt, tgt, clipped;
        logic         fin, act, stop;
        t_segment     follow;
        val = 0;
        fin = 1'b0;
        act = 1'b1;
        if (restart) begin
            cnt_q  = '0;
            half_q = 1'b0;
            done_q = 1'b0;
            lvl_q  = 13'(start_r);
            case (mode_r)
                MODE_TRIANGLE: seg_q = SEG_TRI_UP;
                MODE_CV: begin
                    seg_q = SEG_CV_A;
                    lvl_q = 13'(gnd_r);
                end
                MODE_SWV: seg_q = SEG_SWV;
                default: seg_q = SEG_PULSE;
            endcase
            val = (seg_q == SEG_SWV) ? 32'(lvl_q) + 32'(height_r) : 32'(lvl_q);
        end else if (done_q || seg_q == SEG_IDLE) begin
            val = 32'(lvl_q);
            act = 1'b0;
        end else begin
            cnt_q = cnt_q + 1'b1;
            if (seg_q == SEG_SWV) begin
                if (!half_q) begin
                    half_q = 1'b1;
                    val = (lvl_q >= height_r) ? 32'(lvl_q) - 32'(height_r) : 0;
                    fin = !swv_advance(nxt);
                end else begin
                    if (swv_advance(nxt)) lvl_q = 13'(nxt);
                    half_q = 1'b0;
                    val = 32'(lvl_q) + 32'(height_r);
                end
            end else if (seg_q == SEG_PULSE) begin
                lvl_q = 13'((cnt_q < PULSE_LEAD || cnt_q >= PULSE_END) ? start_r : end_r);
                val = 32'(lvl_q);
                fin = (cnt_q >= PULSE_LAST);
            end else begin
                // A ramp that already sits on its target hands over to the next
                // segment within the same tick.
                val = 32'(lvl_q);
                stop = 1'b0;
                repeat (4) begin
                    if (!stop) begin
                        case (seg_q)
                            SEG_TRI_UP: begin
                                tgt = 32'(end_r);
                                follow = SEG_TRI_DOWN;
                            end
                            SEG_TRI_DOWN: begin
                                tgt = 32'(start_r);
                                follow = SEG_IDLE;
                            end
                            SEG_CV_A: begin
                                tgt = 32'(start_r);
                                follow = SEG_CV_B;
                            end
                            SEG_CV_B: begin
                                tgt = 32'(end_r);
                                follow = SEG_CV_C;
                            end
                            SEG_CV_C: begin
                                tgt = 32'(gnd_r);
                                follow = SEG_IDLE;
                            end
                            default: begin
                                tgt = 32'(lvl_q);
                                follow = SEG_IDLE;
                            end
                        endcase
                        if (lvl_q != tgt) begin
                            lvl_q = (lvl_q < tgt) ? lvl_q + 1'b1 : lvl_q - 1'b1;
                            val = 32'(lvl_q);
                            stop = 1'b1;
                        end else if (follow == SEG_IDLE) begin
                            lvl_q = 13'((seg_q == SEG_TRI_UP || seg_q == SEG_TRI_DOWN) ?
                                        start_r : gnd_r);
                            val = 32'(lvl_q);
                            fin = 1'b1;
                            stop = 1'b1;
                        end else begin
                            seg_q = follow;
                        end
                    end
                end
            end
        end
        if (act && cnt_q >= MAX_SAMPLES - 1) fin = 1'b1;
        clipped = (val > DAC_TOP) ? DAC_TOP : val;
        if (fin) begin
            done_q = 1'b1;
            lvl_q  = 13'(clipped);
            seg_q  = SEG_IDLE;
            half_q = 1'b0;
        end
        r.dac_value    = 12'(clipped);
        r.sample_index = cnt_q;
        r.last_sample  = fin;
        r.active       = act;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_r   = MODE_TRIANGLE;
            start_r  = '0;
            end_r    = '0;
            gnd_r    = 12'd2048;
            step_r   = 12'd1;
            height_r = '0;
            seg_q    = SEG_IDLE;
            lvl_q    = '0;
            cnt_q    = '0;
            half_q   = 1'b0;
            done_q   = 1'b1;
            err_cnt  = 0;
            expected_samples.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.dac_value    = i_m_tdata[11:0];
                got.sample_index = i_m_tdata[24:12];
                got.last_sample  = i_m_tlast;
                got.active       = i_m_tuser;
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, got.dac_value);
                    err_cnt++;
                end else begin
                    want = expected_samples.pop_front();
                    check_field("dac_value", 32'(want.dac_value), 32'(got.dac_value));
                    check_field("sample_index", 32'(want.sample_index),
                                32'(got.sample_index));
                    check_field("last_sample", 32'(want.last_sample),
                                32'(got.last_sample));
                    check_field("active", 32'(want.active), 32'(got.active));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_samples.push_back(next_sample(i_s_tdata[0]));
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_addr))
                    CFG_WAVE_MODE:    mode_r   = t_wave_mode'(i_cfg_data[1:0]);
                    CFG_START_LEVEL:  start_r  = i_cfg_data;
                    CFG_END_LEVEL:    end_r    = i_cfg_data;
                    CFG_GROUND_LEVEL: gnd_r    = i_cfg_data;
                    CFG_STEP_SIZE:    step_r   = i_cfg_data;
                    CFG_PULSE_HEIGHT: height_r = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= expected_samples.size();
        o_errors  <= err_cnt;
    end

endmodule

[tb/voltammetry_waveform_generator_tb.sv]
// Top of the voltammetry waveform generator testbench: clock, reset, register writes,
// restart/tick stimulus under several pacing mixes, and the final verdict.
// Depends on vwg_pkg, voltammetry_waveform_generator and vwg_sample_checker.
`timescale 1ns / 1ps

module voltammetry_waveform_generator_tb;
    import vwg_pkg::*;

    localparam int unsigned MAX_SAMPLES = 4096;
    localparam int unsigned DAC_BITS    = 12;
    localparam int          CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // Bit 0: restart.
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;     // Bits 11:0 dac_value, 24:12 sample_index.
    logic        m_axis_tlast;
    logic        m_axis_tuser;     // Bit 0: active.
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [11:0] i_cfg_data;

    int pending;
    int errors;
    int idle_pct;
    int stall_pct;
    int items_sent;
    int cfg_writes;
    int cycle_cnt;

    voltammetry_waveform_generator #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .DAC_BITS   (DAC_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    vwg_sample_checker #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .DAC_BITS   (DAC_BITS)
    ) u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .i_s_tready(s_axis_tready),
        .i_s_tdata (s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .i_m_tdata (m_axis_tdata),
        .i_m_tlast (m_axis_tlast),
        .i_m_tuser (m_axis_tuser),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .o_pending (pending),
        .o_errors  (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timed out with %0d results outstanding.", pending);
        $display("voltammetry_waveform_generator_tb: done, errors");
        $finish;
    end

    function automatic logic [11:0] rand_level();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] near(input logic [11:0] base, input int span);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    task automatic send_item(input logic restart);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after its last write.
    task automatic write_reg(input t_cfg_index idx, input logic [11:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic load_cfg(input t_wave_mode mode, input logic [11:0] start_lvl,
                            input logic [11:0] end_lvl, input logic [11:0] gnd_lvl,
                            input logic [11:0] step, input logic [11:0] height);
        drain();
        write_reg(CFG_WAVE_MODE, {10'($urandom), mode});
        write_reg(CFG_START_LEVEL, start_lvl);
        write_reg(CFG_END_LEVEL, end_lvl);
        write_reg(CFG_GROUND_LEVEL, gnd_lvl);
        write_reg(CFG_STEP_SIZE, step);
        write_reg(CFG_PULSE_HEIGHT, height);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_cfg();
        logic [11:0] start_lvl, end_lvl, gnd_lvl, step, height;
        start_lvl = rand_level();
        end_lvl   = ($urandom_range(0, 9) == 0) ? rand_level() : near(start_lvl, 24);
        gnd_lvl   = ($urandom_range(0, 3) == 0) ? rand_level() : near(start_lvl, 30);
        step      = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 6));
        height    = ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
        load_cfg(t_wave_mode'($urandom_range(0, 3)), start_lvl, end_lvl, gnd_lvl,
                 step, height);
    endtask

    // One waveform: a restart, then ticks mixed with stray restarts, full drains
    // and register rewrites while the waveform is still running.
    task automatic run_wave(input int ticks);
        send_item(1'b1);
        repeat (ticks) begin
            case ($urandom_range(0, 99))
                0, 1, 2: begin
                    drain();
                    write_reg(t_cfg_index'($urandom_range(0, 5)),
                              $urandom_range(0, 1) ? rand_level()
                                                   : 12'($urandom_range(0, 8)));
                    i_cfg_we <= 1'b0;
                end
                3, 4: drain();
                5, 6: send_item(1'b1);
                default: send_item(1'b0);
            endcase
        end
    endtask

    initial begin
        int phase_mark;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        items_sent    = 0;
        cfg_writes    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Holding after reset, then a flat triangle with the reset registers.
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        // Square-wave at the top of the range: saturation, negative low side, zero step.
        load_cfg(MODE_SWV, 12'd4093, 12'd4095, 12'd0, 12'd0, 12'd4095);
        send_item(1'b1);
        repeat (6) send_item(1'b0);
        // Cyclic from a ground at full scale.
        load_cfg(MODE_CV, 12'd4094, 12'd4095, 12'd4095, 12'd1, 12'd0);
        send_item(1'b1);
        repeat (5) send_item(1'b0);
        // Triangle whose end lies below its start.
        load_cfg(MODE_TRIANGLE, 12'd3, 12'd1, 12'd0, 12'd1, 12'd0);
        send_item(1'b1);
        repeat (5) send_item(1'b0);
        load_cfg(MODE_PULSE, 12'd4095, 12'd0, 12'd0, 12'd1, 12'd0);
        send_item(1'b1);
        repeat (2) send_item(1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            phase_mark = items_sent;
            while (items_sent - phase_mark < 110) begin
                load_random_cfg();
                run_wave($urandom_range(0, 40));
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d input transfers and %0d register writes in all four modes,",
                 items_sent, cfg_writes);
        $display("with live register changes, stray restarts and mixed idle and stall pacing.");
        if (errors == 0 && pending == 0)
            $display("voltammetry_waveform_generator_tb: done, clean");
        else
            $display("voltammetry_waveform_generator_tb: done, errors");
        $finish;
    end

endmodule

[voltammetry_waveform_generator.f]
rtl/vwg_pkg.sv
rtl/voltammetry_waveform_generator.sv
tb/vwg_sample_checker.sv
tb/voltammetry_waveform_generator_tb.sv
